// File: sv/qfpf_pkg.sv
package qfpf_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
	localparam int DIST_WIDTH  = 2 * COORD_WIDTH + 1;
	localparam int NUM_QUADS   = 4;

	// quadrant codes, also the order in which corners go out
	localparam logic [1:0] QUAD_NE = 2'd0;
	localparam logic [1:0] QUAD_NW = 2'd1;
	localparam logic [1:0] QUAD_SE = 2'd2;
	localparam logic [1:0] QUAD_SW = 2'd3;

	// configuration register indexes
	localparam logic CFG_CENTROID_X = 1'b0;
	localparam logic CFG_CENTROID_Y = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [1:0] quad_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   frame_end;
	} in_beat_t;

	typedef struct packed {
		quad_t  quadrant;
		coord_t corner_x;
		coord_t corner_y;
		logic   found;
		logic   last_corner;
	} out_beat_t;

	// classified point with its squared axis distances
	typedef struct packed {
		logic                valid;
		logic                hit;
		quad_t               quad;
		logic [SQ_WIDTH-1:0] sq_x;
		logic [SQ_WIDTH-1:0] sq_y;
		coord_t              px;
		coord_t              py;
		logic                frame_end;
	} sq_stage_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   found;
	} corner_t;

	typedef corner_t [NUM_QUADS-1:0] corner_set_t;

endpackage

// File: sv/qfpf_front.sv
module qfpf_front import qfpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  coord_t    cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	input  logic      s2_go,
	output sq_stage_t stage_s2
);

	coord_t   centroid_x_q;
	coord_t   centroid_y_q;
	in_beat_t beat_s1;
	logic     vld_s1;
	logic     vld_s2;
	logic     s2_acc;
	logic     s1_adv;
	logic     in_acc;

	logic                 gt_x, lt_x, gt_y, lt_y;
	logic [COORD_WIDTH:0] diff_x, diff_y, mag_x, mag_y;
	logic [SQ_WIDTH-1:0]  sq_x, sq_y;

	logic                hit_s2;
	quad_t               quad_s2;
	logic [SQ_WIDTH-1:0] sq_x_s2;
	logic [SQ_WIDTH-1:0] sq_y_s2;
	coord_t              px_s2;
	coord_t              py_s2;
	logic                fe_s2;

	// centroid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centroid_x_q <= '0;
			centroid_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTROID_X: centroid_x_q <= cfg_data;
				CFG_CENTROID_Y: centroid_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake across the two stages
	assign s2_acc   = !vld_s2 || s2_go;
	assign s1_adv   = vld_s1 && s2_acc;
	assign in_stall = vld_s1 && !s2_acc;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			beat_s1 <= in_data;
		end
	end

	// classify against the centroid; axis points get hit = 0
	always_comb begin
		gt_x   = beat_s1.point_x > centroid_x_q;
		lt_x   = beat_s1.point_x < centroid_x_q;
		gt_y   = beat_s1.point_y > centroid_y_q;
		lt_y   = beat_s1.point_y < centroid_y_q;
		diff_x = {beat_s1.point_x[COORD_WIDTH-1], beat_s1.point_x}
			- {centroid_x_q[COORD_WIDTH-1], centroid_x_q};
		diff_y = {beat_s1.point_y[COORD_WIDTH-1], beat_s1.point_y}
			- {centroid_y_q[COORD_WIDTH-1], centroid_y_q};
		mag_x  = diff_x[COORD_WIDTH] ? (~diff_x + (COORD_WIDTH+1)'(1)) : diff_x;
		mag_y  = diff_y[COORD_WIDTH] ? (~diff_y + (COORD_WIDTH+1)'(1)) : diff_y;
		sq_x   = SQ_WIDTH'(mag_x[COORD_WIDTH-1:0]) * SQ_WIDTH'(mag_x[COORD_WIDTH-1:0]);
		sq_y   = SQ_WIDTH'(mag_y[COORD_WIDTH-1:0]) * SQ_WIDTH'(mag_y[COORD_WIDTH-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_adv) begin
			vld_s2 <= 1'b1;
		end else if (s2_go) begin
			vld_s2 <= 1'b0;
		end
	end

	// quad code is {below, left}: NE, NW, SE, SW
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			hit_s2  <= (gt_x || lt_x) && (gt_y || lt_y);
			quad_s2 <= {lt_y, lt_x};
			sq_x_s2 <= sq_x;
			sq_y_s2 <= sq_y;
			px_s2   <= beat_s1.point_x;
			py_s2   <= beat_s1.point_y;
			fe_s2   <= beat_s1.frame_end;
		end
	end

	assign stage_s2 = {vld_s2, hit_s2, quad_s2, sq_x_s2, sq_y_s2, px_s2, py_s2, fe_s2};

endmodule

// File: sv/qfpf_track.sv
module qfpf_track import qfpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sq_stage_t   stage_s2,
	input  logic        snap_free,
	output logic        s2_go,
	output logic        snap_load,
	output corner_set_t snap
);

	logic [DIST_WIDTH-1:0] best_d_q [NUM_QUADS];
	coord_t                best_x_q [NUM_QUADS];
	coord_t                best_y_q [NUM_QUADS];

	logic [DIST_WIDTH-1:0] nxt_d [NUM_QUADS];
	coord_t                nxt_x [NUM_QUADS];
	coord_t                nxt_y [NUM_QUADS];
	logic [DIST_WIDTH-1:0] d2;
	logic                  upd;

	// a frame end waits until the output buffer can take the corners
	assign s2_go     = stage_s2.valid && (!stage_s2.frame_end || snap_free);
	assign snap_load = s2_go && stage_s2.frame_end;

	// replace only on a strictly greater squared distance
	always_comb begin
		d2  = {1'b0, stage_s2.sq_x} + {1'b0, stage_s2.sq_y};
		upd = stage_s2.hit && (d2 > best_d_q[stage_s2.quad]);
		for (int q = 0; q < NUM_QUADS; q++) begin
			nxt_d[q] = best_d_q[q];
			nxt_x[q] = best_x_q[q];
			nxt_y[q] = best_y_q[q];
		end
		if (upd) begin
			nxt_d[stage_s2.quad] = d2;
			nxt_x[stage_s2.quad] = stage_s2.px;
			nxt_y[stage_s2.quad] = stage_s2.py;
		end
	end

	// corners of the closing frame, this point included
	always_comb begin
		for (int q = 0; q < NUM_QUADS; q++) begin
			snap[q].found = nxt_d[q] != '0;
			snap[q].x     = snap[q].found ? nxt_x[q] : '0;
			snap[q].y     = snap[q].found ? nxt_y[q] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUADS; q++) begin
				best_d_q[q] <= '0;
				best_x_q[q] <= '0;
				best_y_q[q] <= '0;
			end
		end else if (s2_go) begin
			for (int q = 0; q < NUM_QUADS; q++) begin
				best_d_q[q] <= stage_s2.frame_end ? '0 : nxt_d[q];
				best_x_q[q] <= stage_s2.frame_end ? '0 : nxt_x[q];
				best_y_q[q] <= stage_s2.frame_end ? '0 : nxt_y[q];
			end
		end
	end

endmodule

// File: sv/qfpf_drain.sv
module qfpf_drain import qfpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        snap_load,
	input  corner_set_t snap,
	output logic        snap_free,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data
);

	corner_set_t buf_q;
	logic        busy_q;
	quad_t       idx_q;
	logic        take;

	assign take      = busy_q && !out_stall;
	assign snap_free = !busy_q || (take && idx_q == QUAD_SW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= QUAD_NE;
		end else if (snap_load) begin
			busy_q <= 1'b1;
			idx_q  <= QUAD_NE;
		end else if (take) begin
			if (idx_q == QUAD_SW) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_load) begin
			buf_q <= snap;
		end
	end

	// corners go out NE, NW, SE, SW
	assign out_valid            = busy_q;
	assign out_data.quadrant    = idx_q;
	assign out_data.corner_x    = buf_q[idx_q].x;
	assign out_data.corner_y    = buf_q[idx_q].y;
	assign out_data.found       = buf_q[idx_q].found;
	assign out_data.last_corner = idx_q == QUAD_SW;

endmodule

// File: sv/quadrant_farthest_point_finder.sv
// channel | dir | payload    | handshake
// --------+-----+------------+-----------------------------------
// in      | in  | in_beat_t  | in_valid / in_stall
// out     | out | out_beat_t | out_valid / out_stall
// cfg     | in  | coord_t    | cfg_we, cfg_index (0 cx, 1 cy)
//
// One point beat per cycle while in_stall is low. Stages: input register,
// classify and square, then compare/update; a frame end loads four corners
// into an output buffer as it leaves the update stage, and they leave one
// per cycle while out_stall is low. A frame end waits in the update stage
// while the previous frame's corners still drain, so frames shorter than
// four points are held back by the drain. Reset clears the centroid, the
// per-quadrant best registers and all valid flags.
module quadrant_farthest_point_finder import qfpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  coord_t    cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	sq_stage_t   stage_s2;
	logic        s2_go;
	logic        snap_load;
	logic        snap_free;
	corner_set_t snap;

	qfpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.s2_go    (s2_go),
		.stage_s2 (stage_s2)
	);

	qfpf_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s2 (stage_s2),
		.snap_free(snap_free),
		.s2_go    (s2_go),
		.snap_load(snap_load),
		.snap     (snap)
	);

	qfpf_drain u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.snap_load(snap_load),
		.snap     (snap),
		.snap_free(snap_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
